// ===== rtl/core/grid_edge_endpoint_index_unit_defines.svh =====
// Assertion macros shared by the grid edge endpoint unit.
`ifndef GRID_EDGE_ENDPOINT_INDEX_UNIT_DEFINES_SVH
`define GRID_EDGE_ENDPOINT_INDEX_UNIT_DEFINES_SVH

// Implication checked in the same cycle.
`define GEE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define GEE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gee_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gee_pkg;

    localparam int EDGE_W      = 33;
    localparam int VERTEX_W    = 30;
    localparam int SIZE_CFG_W  = 11;
    localparam int COUNT_CFG_W = 4;
    localparam int OFFS_REG_W  = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_SIZE_0    = 3'd0,
        REG_DIM_SIZE_1    = 3'd1,
        REG_DIM_SIZE_2    = 3'd2,
        REG_NUM_OFFSETS   = 3'd3,
        REG_OFFSETS_DIM_0 = 3'd4,
        REG_OFFSETS_DIM_1 = 3'd5,
        REG_OFFSETS_DIM_2 = 3'd6
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/core/gee_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gee_div #(
    parameter int NUM_W  = 33,
    parameter int DEN_W  = 4,
    parameter int SIDE_W = 1,
    parameter int STEPS  = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [NUM_W-1:0]  in_num,
    input  wire logic [SIDE_W-1:0] in_side,
    input  wire logic [DEN_W-1:0]  den,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [NUM_W-1:0]       out_quo,
    output logic [DEN_W-1:0]       out_rem,
    output logic [SIDE_W-1:0]      out_side
);

    localparam int STAGES = (NUM_W + STEPS - 1) / STEPS;

    logic              vld_reg  [STAGES];
    logic [DEN_W-1:0]  rem_reg  [STAGES];
    logic [NUM_W-1:0]  word_reg [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];
    logic [STAGES:0]   adv;

    assign adv[STAGES] = out_ready;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic              vld_in;
        logic [DEN_W-1:0]  rem_in;
        logic [NUM_W-1:0]  word_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W-1:0]  rem_next;
        logic [NUM_W-1:0]  word_next;

        if (s == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = '0;
            assign word_in = in_num;
            assign side_in = in_side;
        end else begin : g_rest
            assign vld_in  = vld_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign word_in = word_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        assign adv[s] = !vld_reg[s] || adv[s+1];

        always_comb begin
            logic [DEN_W:0] trial;
            logic           qbit;
            rem_next  = rem_in;
            word_next = word_in;
            trial     = '0;
            qbit      = 1'b0;
            for (int i = 0; i < STEPS; i++) begin
                if (s * STEPS + i < NUM_W) begin
                    trial = {rem_next, word_next[NUM_W-1]};
                    if (trial >= {1'b0, den}) begin
                        trial = trial - {1'b0, den};
                        qbit  = 1'b1;
                    end else begin
                        qbit  = 1'b0;
                    end
                    rem_next  = trial[DEN_W-1:0];
                    word_next = {word_next[NUM_W-2:0], qbit};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (adv[s]) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[s] && vld_in) begin
                rem_reg[s]  <= rem_next;
                word_reg[s] <= word_next;
                side_reg[s] <= side_in;
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[STAGES-1];
    assign out_quo   = word_reg[STAGES-1];
    assign out_rem   = rem_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/grid_edge_endpoint_index_unit.sv =====
// Grid edge endpoint unit: maps an edge number of an implicit 2-D or 3-D grid
// graph to its source or target vertex.
// Input channel s_*: edge index and which end is wanted, valid/ready.
// Result channel m_*: row-major vertex index and an in-range flag.
// Configuration: cfg_wr_en/cfg_wr_idx/cfg_wr_data write one register per
// cycle; write only while no transfer is in flight.
// Throughput: one transfer per cycle in each direction while m_ready is high.
// Structure: three pipelined long dividers (edge by offset count, 4 quotient
// bits a stage; vertex by plane stride and remainder by row stride, 2 bits a
// stage) plus a multiply stage and an output register.
// Reset: synchronous, active low; empties the pipeline and loads the grid
// registers with size 1, one offset and zero offsets.
// Stall: when m_ready is low, each stage holds until the stage after it has
// room, so bubbles still fill and s_ready drops only when the pipe is full.
`timescale 1ns / 1ps
`default_nettype none

`include "grid_edge_endpoint_index_unit_defines.svh"

module grid_edge_endpoint_index_unit #(
    parameter int DIMS        = 3,
    parameter int MAX_OFFSETS = 8,
    parameter int DIM_BITS    = 10,
    parameter int OFFSET_BITS = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [gee_pkg::EDGE_W-1:0]      s_edge_index,
    input  wire logic                            s_which_end,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [gee_pkg::VERTEX_W-1:0]         m_vertex_index,
    output logic                                 m_edge_in_range,
    input  wire logic                            cfg_wr_en,
    input  wire logic [gee_pkg::CFG_IDX_W-1:0]   cfg_wr_idx,
    input  wire logic [gee_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    import gee_pkg::*;

    localparam int SW  = DIM_BITS + 1;
    localparam int OB  = OFFSET_BITS;
    localparam int KW  = COUNT_CFG_W;
    localparam int CW  = DIM_BITS;
    localparam int TW  = CW + 2 * SW + 1;
    localparam int PAD = OFFS_REG_W + MAX_OFFSETS * OB;

    typedef struct packed {
        logic                  which_end;
        logic [EDGE_W-1:0]     edge_index;
    } side1_t;

    typedef struct packed {
        logic                  which_end;
        logic [KW-1:0]         k;
        logic [VERTEX_W-1:0]   src;
        logic                  in_range;
    } side2_t;

    typedef struct packed {
        logic                  which_end;
        logic [KW-1:0]         k;
        logic [VERTEX_W-1:0]   src;
        logic                  in_range;
        logic                  ok0;
        logic [CW-1:0]         c0;
    } side3_t;

    function automatic logic [SW-1:0] eff_size(input logic [SIZE_CFG_W-1:0] s);
        logic [SW-1:0] r;
        r = SW'(s);
        if (s == '0) begin
            r = SW'(1);
        end else if (32'(s) > (32'd1 << DIM_BITS)) begin
            r = SW'(32'd1 << DIM_BITS);
        end
        return r;
    endfunction

    function automatic logic [OB-1:0] off_field(input logic [OFFS_REG_W-1:0] r,
                                                input logic [KW-1:0] k);
        logic [PAD-1:0] pad;
        logic [OB-1:0]  f;
        pad = PAD'(r);
        f   = '0;
        for (int j = 0; j < MAX_OFFSETS; j++) begin
            if (k == KW'(j)) begin
                f = pad[j*OB +: OB];
            end
        end
        return f;
    endfunction

    // configuration registers
    logic [SIZE_CFG_W-1:0]  dim_size_reg [3];
    logic [COUNT_CFG_W-1:0] num_off_reg;
    logic [OFFS_REG_W-1:0]  offs_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_size_reg[0] <= SIZE_CFG_W'(1);
            dim_size_reg[1] <= SIZE_CFG_W'(1);
            dim_size_reg[2] <= SIZE_CFG_W'(1);
            num_off_reg     <= COUNT_CFG_W'(1);
            offs_reg[0]     <= '0;
            offs_reg[1]     <= '0;
            offs_reg[2]     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_idx))
                REG_DIM_SIZE_0:    dim_size_reg[0] <= cfg_wr_data[SIZE_CFG_W-1:0];
                REG_DIM_SIZE_1:    dim_size_reg[1] <= cfg_wr_data[SIZE_CFG_W-1:0];
                REG_DIM_SIZE_2:    dim_size_reg[2] <= cfg_wr_data[SIZE_CFG_W-1:0];
                REG_NUM_OFFSETS:   num_off_reg     <= cfg_wr_data[COUNT_CFG_W-1:0];
                REG_OFFSETS_DIM_0: offs_reg[0]     <= cfg_wr_data[OFFS_REG_W-1:0];
                REG_OFFSETS_DIM_1: offs_reg[1]     <= cfg_wr_data[OFFS_REG_W-1:0];
                REG_OFFSETS_DIM_2: offs_reg[2]     <= cfg_wr_data[OFFS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes and derived strides
    logic [SW-1:0] size0, size1, size2;
    logic [KW-1:0] n_eff;

    assign size0 = eff_size(dim_size_reg[0]);
    assign size1 = eff_size(dim_size_reg[1]);
    assign size2 = (DIMS == 3) ? eff_size(dim_size_reg[2]) : SW'(1);

    always_comb begin
        n_eff = num_off_reg;
        if (num_off_reg == '0) begin
            n_eff = KW'(1);
        end else if (32'(num_off_reg) > 32'(MAX_OFFSETS)) begin
            n_eff = KW'(MAX_OFFSETS);
        end
    end

    logic [2*SW-1:0]    stride0_reg, stride0_next;
    logic [3*SW-1:0]    verts_reg;
    logic [3*SW+KW-1:0] vn_reg;

    assign stride0_next = size1 * size2;

    always_ff @(posedge aclk) begin
        stride0_reg <= stride0_next;
        verts_reg   <= stride0_reg * size0;
        vn_reg      <= verts_reg * n_eff;
    end

    // edge / offset count
    side1_t              side1_in, side1_out;
    logic                d1_out_valid, d1_out_ready;
    logic [EDGE_W-1:0]   d1_quo;
    logic [KW-1:0]       d1_rem;

    assign side1_in.which_end  = s_which_end;
    assign side1_in.edge_index = s_edge_index;

    gee_div #(
        .NUM_W (EDGE_W),
        .DEN_W (KW),
        .SIDE_W($bits(side1_t)),
        .STEPS (4)
    ) u_div_edge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_num   (s_edge_index),
        .in_side  (side1_in),
        .den      (n_eff),
        .out_valid(d1_out_valid),
        .out_ready(d1_out_ready),
        .out_quo  (d1_quo),
        .out_rem  (d1_rem),
        .out_side (side1_out)
    );

    // vertex / plane stride
    side2_t              side2_in, side2_out;
    logic                d2_out_valid, d2_out_ready;
    logic [EDGE_W-1:0]   d2_quo;
    logic [2*SW-1:0]     d2_rem;

    assign side2_in.which_end = side1_out.which_end;
    assign side2_in.k         = d1_rem;
    assign side2_in.src       = d1_quo[VERTEX_W-1:0];
    assign side2_in.in_range  = (EDGE_W + 3*SW + KW)'(side1_out.edge_index)
                                < (EDGE_W + 3*SW + KW)'(vn_reg);

    gee_div #(
        .NUM_W (EDGE_W),
        .DEN_W (2*SW),
        .SIDE_W($bits(side2_t)),
        .STEPS (2)
    ) u_div_plane (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (d1_out_valid),
        .in_ready (d1_out_ready),
        .in_num   (d1_quo),
        .in_side  (side2_in),
        .den      (stride0_reg),
        .out_valid(d2_out_valid),
        .out_ready(d2_out_ready),
        .out_quo  (d2_quo),
        .out_rem  (d2_rem),
        .out_side (side2_out)
    );

    // check the slowest coordinate, then remainder / row stride
    logic [OB-1:0]       off0;
    logic [EDGE_W+1:0]   c0_sum;
    side3_t              side3_in, side3_out;
    logic                d3_out_valid, d3_out_ready;
    logic [2*SW-1:0]     d3_quo;
    logic [SW-1:0]       d3_rem;

    assign off0   = off_field(offs_reg[0], side2_out.k);
    assign c0_sum = {2'b00, d2_quo} + {{(EDGE_W+2-OB){off0[OB-1]}}, off0};

    assign side3_in.which_end = side2_out.which_end;
    assign side3_in.k         = side2_out.k;
    assign side3_in.src       = side2_out.src;
    assign side3_in.in_range  = side2_out.in_range;
    assign side3_in.ok0       = !c0_sum[EDGE_W+1]
                                && (c0_sum[EDGE_W:0] < (EDGE_W+1)'(size0));
    assign side3_in.c0        = c0_sum[CW-1:0];

    gee_div #(
        .NUM_W (2*SW),
        .DEN_W (SW),
        .SIDE_W($bits(side3_t)),
        .STEPS (2)
    ) u_div_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (d2_out_valid),
        .in_ready (d2_out_ready),
        .in_num   (d2_rem),
        .in_side  (side3_in),
        .den      (size2),
        .out_valid(d3_out_valid),
        .out_ready(d3_out_ready),
        .out_quo  (d3_quo),
        .out_rem  (d3_rem),
        .out_side (side3_out)
    );

    // remaining coordinates and products
    logic [OB-1:0]     off1, off2;
    logic [2*SW+1:0]   c1_sum;
    logic [SW+1:0]     c2_sum;
    logic              ok1, ok2;

    assign off1   = off_field(offs_reg[1], side3_out.k);
    assign off2   = off_field(offs_reg[2], side3_out.k);
    assign c1_sum = {2'b00, d3_quo} + {{(2*SW+2-OB){off1[OB-1]}}, off1};
    assign c2_sum = {2'b00, d3_rem} + {{(SW+2-OB){off2[OB-1]}}, off2};
    assign ok1    = !c1_sum[2*SW+1] && (c1_sum[2*SW:0] < (2*SW+1)'(size1));
    assign ok2    = (DIMS != 3)
                    || (!c2_sum[SW+1] && (c2_sum[SW:0] < (SW+1)'(size2)));

    logic                p1_vld_reg, p1_adv;
    logic [CW+2*SW-1:0]  p1_prod0_reg;
    logic [CW+SW-1:0]    p1_prod1_reg;
    logic [CW-1:0]       p1_c2_reg;
    logic                p1_use_tgt_reg;
    logic [VERTEX_W-1:0] p1_src_reg;
    logic                p1_inr_reg;

    logic                p2_vld_reg, p2_adv;
    logic [VERTEX_W-1:0] p2_vertex_reg;
    logic                p2_inr_reg;
    logic [TW-1:0]       target;

    assign p2_adv       = !p2_vld_reg || m_ready;
    assign p1_adv       = !p1_vld_reg || p2_adv;
    assign d3_out_ready = p1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end else begin
            if (p1_adv) begin
                p1_vld_reg <= d3_out_valid;
            end
            if (p2_adv) begin
                p2_vld_reg <= p1_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv && d3_out_valid) begin
            p1_prod0_reg   <= side3_out.c0 * stride0_reg;
            p1_prod1_reg   <= c1_sum[CW-1:0] * size2;
            p1_c2_reg      <= (DIMS == 3) ? c2_sum[CW-1:0] : '0;
            p1_use_tgt_reg <= side3_out.which_end && side3_out.ok0 && ok1 && ok2;
            p1_src_reg     <= side3_out.src;
            p1_inr_reg     <= side3_out.in_range;
        end
    end

    assign target = TW'(p1_prod0_reg) + TW'(p1_prod1_reg) + TW'(p1_c2_reg);

    always_ff @(posedge aclk) begin
        if (p2_adv && p1_vld_reg) begin
            p2_vertex_reg <= p1_use_tgt_reg ? VERTEX_W'(target) : p1_src_reg;
            p2_inr_reg    <= p1_inr_reg;
        end
    end

    assign m_valid         = p2_vld_reg;
    assign m_vertex_index  = p2_vertex_reg;
    assign m_edge_in_range = p2_inr_reg;

    `GEE_ASSERT_NOW(a_p1_stall_cause, aclk, aresetn, p1_vld_reg && !p1_adv, p2_vld_reg && !m_ready, "final stage stalled without a blocked output")
    `GEE_ASSERT_NOW(a_count_legal, aclk, aresetn, 1'b1, (n_eff != '0) && (32'(n_eff) <= 32'(MAX_OFFSETS)), "effective offset count out of range")
    `GEE_ASSERT_NEXT(a_stride_track, aclk, aresetn, 1'b1, stride0_reg == $past(stride0_next), "plane stride did not follow the size registers")

endmodule

`default_nettype wire

// ===== sim/endpoint_scoreboard.sv =====
`timescale 1ns / 1ps

class endpoint_scoreboard;
    logic [29:0] exp_vertex[$];
    logic        exp_in_range[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    function void note_input(logic [29:0] vertex, logic in_range);
        exp_vertex.push_back(vertex);
        exp_in_range.push_back(in_range);
    endfunction

    function int pending();
        return exp_vertex.size();
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_result(logic [29:0] vertex, logic in_range);
        logic [29:0] ev;
        logic        er;
        if (exp_vertex.size() == 0) begin
            report($sformatf("unexpected transfer vertex=%0d", vertex));
        end else begin
            ev = exp_vertex.pop_front();
            er = exp_in_range.pop_front();
            if (vertex !== ev)
                report($sformatf("vertex_index got %0d want %0d", vertex, ev));
            if (in_range !== er)
                report($sformatf("edge_in_range got %0d want %0d", in_range, er));
        end
    endtask
endclass

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import gee_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [EDGE_W-1:0]     s_edge_index;
    logic                  s_which_end;
    logic                  m_valid;
    logic                  m_ready;
    logic [VERTEX_W-1:0]   m_vertex_index;
    logic                  m_edge_in_range;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_idx;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    logic [10:0] grid_size[3];
    logic [3:0]  offset_count;
    logic [31:0] offset_reg[3];

    endpoint_scoreboard sb;
    int idle_cycles;
    int stall_mode;
    int stall_count;
    logic [15:0] stall_pattern;

    grid_edge_endpoint_index_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_edge_index(s_edge_index), .s_which_end(s_which_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_vertex_index(m_vertex_index), .m_edge_in_range(m_edge_in_range),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_idx(cfg_wr_idx), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    function automatic longint unsigned clamp_size(logic [10:0] s);
        if (s == 0) return 1;
        if (s > 1024) return 1024;
        return s;
    endfunction

    function automatic longint unsigned clamp_count();
        if (offset_count == 0) return 1;
        if (offset_count > 8) return 8;
        return offset_count;
    endfunction

    function automatic longint unsigned edge_total();
        return clamp_size(grid_size[0]) * clamp_size(grid_size[1])
               * clamp_size(grid_size[2]) * clamp_count();
    endfunction

    task automatic predict_endpoint(input logic [32:0] e, input logic which,
                                    output logic [29:0] vertex, output logic in_range);
        longint unsigned sz[3];
        longint unsigned stride[3];
        longint unsigned n, src, k, rest, tgt;
        longint c;
        logic [3:0] nib;
        bit ok;
        n = clamp_count();
        for (int i = 0; i < 3; i++) sz[i] = clamp_size(grid_size[i]);
        stride[2] = 1;
        stride[1] = sz[2];
        stride[0] = sz[1] * sz[2];
        src = e / n;
        k = e % n;
        rest = src;
        tgt = 0;
        ok = 1;
        for (int i = 0; i < 3; i++) begin
            if (ok) begin
                nib = offset_reg[i][k*4 +: 4];
                c = longint'(rest / stride[i]) + longint'($signed(nib));
                if (c < 0 || longint'(c) >= longint'(sz[i])) begin
                    ok = 0;
                end else begin
                    tgt += longint'(c) * stride[i];
                    rest = rest % stride[i];
                end
            end
        end
        vertex = (which && ok) ? tgt[29:0] : src[29:0];
        in_range = (e < sz[0] * sz[1] * sz[2] * n);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= idx;
        cfg_wr_data <= data;
        case (idx)
            REG_DIM_SIZE_0:    grid_size[0] = data[10:0];
            REG_DIM_SIZE_1:    grid_size[1] = data[10:0];
            REG_DIM_SIZE_2:    grid_size[2] = data[10:0];
            REG_NUM_OFFSETS:   offset_count = data[3:0];
            REG_OFFSETS_DIM_0: offset_reg[0] = data;
            REG_OFFSETS_DIM_1: offset_reg[1] = data;
            REG_OFFSETS_DIM_2: offset_reg[2] = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic configure(input logic [10:0] s0, input logic [10:0] s1,
                             input logic [10:0] s2, input logic [3:0] cnt,
                             input logic [31:0] o0, input logic [31:0] o1,
                             input logic [31:0] o2);
        write_reg(REG_DIM_SIZE_0, {21'h1fffff, s0});
        write_reg(REG_DIM_SIZE_1, {21'd0, s1});
        write_reg(REG_DIM_SIZE_2, {21'd0, s2});
        write_reg(REG_NUM_OFFSETS, {28'hfffffff, cnt});
        write_reg(REG_OFFSETS_DIM_0, o0);
        write_reg(REG_OFFSETS_DIM_1, o1);
        write_reg(REG_OFFSETS_DIM_2, o2);
        write_reg(REG_UNUSED, $urandom);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_edge(input logic [32:0] e, input logic which);
        logic [29:0] v;
        logic        r;
        s_valid      <= 1'b1;
        s_edge_index <= e;
        s_which_end  <= which;
        do @(posedge aclk); while (!s_ready);
        predict_endpoint(e, which, v, r);
        sb.note_input(v, r);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    function automatic logic [32:0] pick_edge();
        longint unsigned total;
        logic [63:0] r;
        total = edge_total();
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return r % total;
            6, 7:    return total - 2 + $urandom_range(0, 3);
            8:       return r[32:0];
            default: return $urandom_range(0, 1) ? 33'h1ffffffff : 33'd0;
        endcase
    endfunction

    function automatic logic [10:0] pick_size();
        case ($urandom_range(0, 11))
            0:       return 11'd0;
            1:       return 11'd1024;
            2:       return 11'd2047;
            3:       return $urandom;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    function automatic logic [31:0] pick_offsets();
        case ($urandom_range(0, 7))
            0:       return 32'h88888888;
            1:       return 32'h77777777;
            2:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_burst(input int count);
        int left;
        left = $urandom_range(1, 30);
        for (int i = 0; i < count; i++) begin
            send_edge(pick_edge(), $urandom_range(0, 1));
            left--;
            if (left == 0) begin
                left = $urandom_range(1, 30);
                if ($urandom_range(0, 2) != 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge aclk);
                end
            end
        end
        s_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready     <= 1'b0;
            stall_mode  <= 0;
            stall_count <= 0;
            stall_pattern <= 16'hb3c5;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= stall_pattern[15];
                2:       m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_vertex_index, m_edge_in_range);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        idle_cycles   = 0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_edge_index <= '0;
        s_which_end  <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_idx   <= '0;
        cfg_wr_data  <= '0;
        grid_size[0] = 1; grid_size[1] = 1; grid_size[2] = 1;
        offset_count = 1;
        offset_reg[0] = 0; offset_reg[1] = 0; offset_reg[2] = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_edge(33'd0, 1'b1);
        send_edge(33'd1, 1'b0);
        drain();

        configure(11'd3, 11'd4, 11'd5, 4'd8, 32'h81f07100, 32'h7f18e001, 32'h1f8070f1);
        for (int w = 0; w < 2; w++) begin
            send_edge(33'd0, w);
            send_edge(33'd7, w);
            send_edge(33'd479, w);
            send_edge(33'd480, w);
            send_edge(33'd250, w);
            send_edge(33'h1ffffffff, w);
        end
        drain();
        configure(11'd0, 11'd2047, 11'd1, 4'd0, 32'h0, 32'h0, 32'hffffffff);
        send_edge(33'd5, 1'b1);
        send_edge(33'd1024, 1'b1);
        send_edge(33'h1ffffffff, 1'b1);
        drain();
        configure(11'd1024, 11'd1024, 11'd1024, 4'd15, 32'h77777777, 32'h88888888,
                  32'h12345678);
        send_edge(33'h1fffffff7, 1'b1);
        send_edge(33'h1fffffff8, 1'b0);
        send_edge(33'h1ffffffff, 1'b1);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            configure(pick_size(), pick_size(), pick_size(),
                      (phase == 0) ? 4'd8 : (phase == 1) ? 4'd1 : 4'($urandom_range(0, 15)),
                      pick_offsets(), pick_offsets(), pick_offsets());
            run_burst(50);
            if (phase == 3) begin
                while (sb.pending() != 0) @(posedge aclk);
            end
            run_burst(50);
            drain();
        end

        while (sb.pending() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
